@@ src/tkla_pkg.sv @@
// ----------------------------------------------------------------------------
// Terminal keystroke line assembler package
// Shared command type, control codes, byte constants and the VT100 key table.
// ----------------------------------------------------------------------------
`default_nettype none

package tkla_pkg;

    localparam int ESC_MAX     = 5;
    localparam int NUM_KEYS    = 22;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    localparam logic [2:0] ESC_OVER = 3'd6;
    localparam logic [4:0] KEY_TAB  = 5'd22;

    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_BS  = 8'h08;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_LF  = 8'h0a;
    localparam logic [7:0] CH_CR  = 8'h0d;
    localparam logic [7:0] CH_ESC = 8'h1b;
    localparam logic [7:0] CH_DEL = 8'h7f;

    localparam logic [1:0] OP_NOP    = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_BKSP   = 2'd2;
    localparam logic [1:0] OP_KEY    = 2'd3;

    typedef struct packed {
        logic       pre_flush;
        logic [1:0] op;
        logic [7:0] data;
    } cmd_t;

    typedef struct packed {
        logic       hit;
        logic [4:0] code;
    } key_hit_t;

    typedef logic [ESC_MAX-1:0][7:0] esc_seq_t;

    localparam esc_seq_t KEY_SEQ [NUM_KEYS] = '{
        40'h000000001b, 40'h0000415b1b, 40'h0000425b1b, 40'h0000435b1b,
        40'h0000445b1b, 40'h007e365b1b, 40'h007e355b1b, 40'h007e345b1b,
        40'h007e315b1b, 40'h007e325b1b, 40'h0000504f1b, 40'h0000514f1b,
        40'h0000524f1b, 40'h0000534f1b, 40'h7e35315b1b, 40'h7e37315b1b,
        40'h7e38315b1b, 40'h7e39315b1b, 40'h7e30325b1b, 40'h7e31325b1b,
        40'h7e33325b1b, 40'h7e34325b1b
    };

    localparam logic [2:0] KEY_LEN [NUM_KEYS] = '{
        3'd1, 3'd3, 3'd3, 3'd3, 3'd3, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd3,
        3'd3, 3'd3, 3'd3, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5
    };

    function automatic key_hit_t key_match(input esc_seq_t seq, input logic [2:0] cnt);
        key_hit_t r;
        logic     eq;
        r = '0;
        for (int k = NUM_KEYS - 1; k >= 0; k--)
        begin
            eq = (KEY_LEN[k] == cnt);
            for (int j = 0; j < ESC_MAX; j++)
            begin
                if ((j < int'(cnt)) && (seq[j] != KEY_SEQ[k][j]))
                begin
                    eq = 1'b0;
                end
            end
            if (eq)
            begin
                r.hit  = 1'b1;
                r.code = 5'(k);
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ src/terminal_keystroke_line_assembler_unit.sv @@
// A key token reaches the output through the command queue, command register and
// output register; flushed characters also pass the line buffer's read data register.
// Throughput: one byte per cycle is taken while the four-entry command queue has room.
// The line engine steps each command through S_IDLE and S_EXEC, and each flushed
// character through S_RD and S_EMIT for its single-port buffer's registered read data.
// Reset clears the line length, the escape and discard state, the queue and the output.
// ----------------------------------------------------------------------------
// Terminal keystroke line assembler
// Assembles terminal bytes into edited lines and decodes VT100 key sequences.
// ----------------------------------------------------------------------------
`default_nettype none

module terminal_keystroke_line_assembler_unit
    import tkla_pkg::*;
#(
    parameter int LINE_CAPACITY = 32
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] in_byte
    input  wire logic        s_tuser,   // [0] chunk_first
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [7:0] line_char, [12:8] key_code, rest zero
    output logic             m_tuser,   // [0] record_kind
    output logic             m_tlast
);

    logic accept;
    logic push;
    cmd_t push_cmd;
    logic full;
    logic pop;
    cmd_t pop_cmd;
    logic empty;

    assign s_tready = !full;
    assign accept   = s_tvalid && s_tready;

    tkla_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .in_byte     (s_tdata),
        .chunk_first (s_tuser),
        .chunk_last  (s_tlast),
        .push        (push),
        .push_cmd    (push_cmd)
    );

    tkla_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (full),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .empty    (empty)
    );

    tkla_back #(
        .LINE_CAPACITY (LINE_CAPACITY)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .empty    (empty),
        .pop_cmd  (pop_cmd),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

@@ src/tkla_front.sv @@
// ----------------------------------------------------------------------------
// Keystroke front end
// Tracks chunk and escape state, decodes key sequences and turns each
// accepted byte into at most one command for the line engine.
// ----------------------------------------------------------------------------
`default_nettype none

module tkla_front
    import tkla_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       accept,
    input  wire logic [7:0] in_byte,
    input  wire logic       chunk_first,
    input  wire logic       chunk_last,
    output logic            push,
    output cmd_t            push_cmd
);

    logic       esc_mode_reg, esc_mode_next;
    logic       discard_reg, discard_next;
    logic [2:0] esc_cnt_reg, esc_cnt_next;
    esc_seq_t   esc_bytes_reg, esc_bytes_next;
    key_hit_t   match;
    logic       taken;
    cmd_t       cmd;

    always_comb
    begin
        esc_mode_next  = esc_mode_reg;
        discard_next   = discard_reg;
        esc_cnt_next   = esc_cnt_reg;
        esc_bytes_next = esc_bytes_reg;
        cmd            = '0;
        taken          = 1'b0;

        if (chunk_first)
        begin
            esc_mode_next = 1'b0;
            discard_next  = 1'b0;
            esc_cnt_next  = '0;
            if (in_byte == CH_ESC)
            begin
                cmd.pre_flush     = 1'b1;
                esc_mode_next     = 1'b1;
                esc_bytes_next[0] = in_byte;
                esc_cnt_next      = 3'd1;
                taken             = 1'b1;
            end
        end

        if (!taken)
        begin
            if (esc_mode_next)
            begin
                if (esc_cnt_next < 3'(ESC_MAX))
                begin
                    esc_bytes_next[esc_cnt_next] = in_byte;
                    esc_cnt_next                 = esc_cnt_next + 3'd1;
                end
                else
                begin
                    esc_cnt_next = ESC_OVER;
                end
            end
            else if (!discard_next)
            begin
                unique case (in_byte)
                    CH_BS, CH_DEL:
                    begin
                        cmd.op = OP_BKSP;
                    end
                    CH_TAB:
                    begin
                        cmd.op   = OP_KEY;
                        cmd.data = {3'b000, KEY_TAB};
                    end
                    CH_CR, CH_LF:
                    begin
                        cmd.pre_flush = 1'b1;
                        discard_next  = 1'b1;
                    end
                    CH_NUL:
                    begin
                        cmd.op = OP_NOP;
                    end
                    default:
                    begin
                        cmd.op   = OP_APPEND;
                        cmd.data = in_byte;
                    end
                endcase
            end
        end

        match = key_match(esc_bytes_next, esc_cnt_next);

        if (chunk_last)
        begin
            if (esc_mode_next && match.hit)
            begin
                cmd.op   = OP_KEY;
                cmd.data = {3'b000, match.code};
            end
            esc_mode_next = 1'b0;
            discard_next  = 1'b0;
            esc_cnt_next  = '0;
        end
    end

    assign push     = accept && (cmd.pre_flush || (cmd.op != OP_NOP));
    assign push_cmd = cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            esc_mode_reg <= 1'b0;
            discard_reg  <= 1'b0;
            esc_cnt_reg  <= '0;
        end
        else if (accept)
        begin
            esc_mode_reg <= esc_mode_next;
            discard_reg  <= discard_next;
            esc_cnt_reg  <= esc_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            esc_bytes_reg <= esc_bytes_next;
        end
    end

endmodule

`default_nettype wire

@@ src/tkla_fifo.sv @@
// ----------------------------------------------------------------------------
// Command queue
// Short first-in first-out queue of commands between front end and engine.
// ----------------------------------------------------------------------------
`default_nettype none

module tkla_fifo
    import tkla_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire cmd_t push_cmd,
    output logic      full,
    input  wire logic pop,
    output cmd_t      pop_cmd,
    output logic      empty
);

    cmd_t                store [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_AW:0]   count_reg;
    logic                do_push;
    logic                do_pop;

    assign full    = (count_reg == (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign pop_cmd = store[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

@@ src/tkla_back.sv @@
// ----------------------------------------------------------------------------
// Line engine
// Owns the line buffer, carries out queued commands and drives the
// registered result stream.
// ----------------------------------------------------------------------------
`default_nettype none

module tkla_back
    import tkla_pkg::*;
#(
    parameter int LINE_CAPACITY = 32
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         empty,
    input  wire cmd_t         pop_cmd,
    output logic              pop,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [15:0]       m_tdata,
    output logic              m_tuser,
    output logic              m_tlast
);

    localparam int AW = (LINE_CAPACITY > 1) ? $clog2(LINE_CAPACITY) : 1;
    localparam int LW = $clog2(LINE_CAPACITY + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_RD   = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    logic [7:0]    line_mem [LINE_CAPACITY];
    logic [1:0]    state_reg, state_next;
    cmd_t          cmd_reg, cmd_next;
    logic [LW-1:0] len_reg, len_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [7:0]    rd_data_reg;
    logic          wr_en;

    logic          out_valid_reg;
    logic          out_kind_reg;
    logic [7:0]    out_char_reg;
    logic [4:0]    out_key_reg;
    logic          out_last_reg;

    logic          out_free;
    logic          load;
    logic          ld_kind;
    logic [7:0]    ld_char;
    logic [4:0]    ld_key;
    logic          ld_last;
    logic [LW-1:0] idx_ext;

    assign out_free = !out_valid_reg || m_tready;
    assign idx_ext  = LW'(idx_reg) + LW'(1);

    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        len_next   = len_reg;
        idx_next   = idx_reg;
        pop        = 1'b0;
        wr_en      = 1'b0;
        load       = 1'b0;
        ld_kind    = 1'b0;
        ld_char    = '0;
        ld_key     = '0;
        ld_last    = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (!empty)
                begin
                    pop        = 1'b1;
                    cmd_next   = pop_cmd;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (cmd_reg.pre_flush && (len_reg != '0))
                begin
                    cmd_next.pre_flush = 1'b0;
                    idx_next           = '0;
                    state_next         = S_RD;
                end
                else
                begin
                    unique case (cmd_reg.op)
                        OP_NOP:
                        begin
                            state_next = S_IDLE;
                        end
                        OP_APPEND:
                        begin
                            wr_en    = 1'b1;
                            len_next = len_reg + LW'(1);
                            if (len_reg == LW'(LINE_CAPACITY - 1))
                            begin
                                cmd_next.op        = OP_NOP;
                                cmd_next.pre_flush = 1'b0;
                                idx_next           = '0;
                                state_next         = S_RD;
                            end
                            else
                            begin
                                state_next = S_IDLE;
                            end
                        end
                        OP_BKSP:
                        begin
                            if (len_reg != '0)
                            begin
                                len_next = len_reg - LW'(1);
                            end
                            state_next = S_IDLE;
                        end
                        OP_KEY:
                        begin
                            if (out_free)
                            begin
                                load       = 1'b1;
                                ld_kind    = 1'b1;
                                ld_key     = cmd_reg.data[4:0];
                                ld_last    = 1'b1;
                                state_next = S_IDLE;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_RD:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    load    = 1'b1;
                    ld_char = rd_data_reg;
                    ld_last = (idx_ext == len_reg);
                    if (idx_ext == len_reg)
                    begin
                        len_next   = '0;
                        state_next = S_EXEC;
                    end
                    else
                    begin
                        idx_next   = idx_reg + AW'(1);
                        state_next = S_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            len_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            len_reg   <= len_next;
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        idx_reg <= idx_next;
        if (load)
        begin
            out_kind_reg <= ld_kind;
            out_char_reg <= ld_char;
            out_key_reg  <= ld_key;
            out_last_reg <= ld_last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            line_mem[len_reg[AW-1:0]] <= cmd_reg.data;
        end
        if (state_reg == S_RD)
        begin
            rd_data_reg <= line_mem[idx_reg];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_key_reg, out_char_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

@@ src/tkla_checker.sv @@
// ----------------------------------------------------------------------------
// Port checker
// Watches both streams of the line assembler for malformed requests.
// ----------------------------------------------------------------------------
`default_nettype none

module tkla_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [7:0]  s_tdata,
    input wire logic        s_tuser,
    input wire logic        s_tlast,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata,
    input wire logic        m_tuser,
    input wire logic        m_tlast
);

    a_in_known: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid |-> !$isunknown({s_tready, s_tdata, s_tuser, s_tlast}))
        else $error("input request carries unknown bits");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result request changed");

    a_key_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tlast && (m_tdata[7:0] == 8'h00))
        else $error("key token not a single clean request");

    a_char_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> (m_tdata[12:8] == 5'd0))
        else $error("line character carries a key code");

    a_key_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[12:8] <= 5'd22) && (m_tdata[15:13] == 3'd0))
        else $error("key code out of range");

endmodule

bind terminal_keystroke_line_assembler_unit tkla_checker u_tkla_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire
